// ----- src/bba_pkg.sv -----
// Shared types and constants for the block bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   // Bitmap word geometry
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_BAD_ID   = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_DATA_START  = 2'd0;
   localparam logic [1:0] REG_DATA_BASE   = 2'd1;
   localparam logic [1:0] REG_BLOCK_SHIFT = 2'd2;

   typedef struct packed {
      logic [13:0] data_start;
      logic [23:0] data_base;
      logic [3:0]  block_size_log2;
   } cfg_type;

   typedef struct packed {
      logic [5:0]       free_cnt;
      logic             any_free;
      logic [BIT_W-1:0] first_free;
   } scan_type;

endpackage

`default_nettype wire

// ----- src/bba_bitmap_ram.sv -----
// Used-bit map storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bba_bitmap_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [bba_pkg::WORD_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [bba_pkg::WORD_W-1:0] rd_data
);
   import bba_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/bba_word_scan.sv -----
// Shared word unit: masks one bitmap word, counts its free bits, finds the lowest free bit.
`timescale 1ns / 1ps
`default_nettype none

module bba_word_scan #(
   parameter int BLOCKS = 16384,
   parameter int WAW    = 9
) (
   input  wire logic [bba_pkg::WORD_W-1:0] word,
   input  wire logic [WAW-1:0]             word_idx,
   input  wire logic                       first_word,
   input  wire logic [bba_pkg::BIT_W-1:0]  start_bit,
   output bba_pkg::scan_type               scan
);
   import bba_pkg::*;

   logic [WORD_W-1:0] free_bits;
   logic [3:0]        byte_cnt [4];

   always_comb begin
      // a bit is free when clear, at or above the start bit, and inside the map
      for (int b = 0; b < WORD_W; b++) begin
         free_bits[b] = !word[b];
         if (first_word && (BIT_W'(b) < start_bit)) begin
            free_bits[b] = 1'b0;
         end
         if (32'({word_idx, BIT_W'(b)}) >= BLOCKS) begin
            free_bits[b] = 1'b0;
         end
      end

      for (int i = 0; i < 4; i++) begin
         byte_cnt[i] = 4'd0;
         for (int j = 0; j < 8; j++) begin
            byte_cnt[i] = byte_cnt[i] + 4'(free_bits[8*i+j]);
         end
      end
      scan.free_cnt = (6'(byte_cnt[0]) + 6'(byte_cnt[1]))
                    + (6'(byte_cnt[2]) + 6'(byte_cnt[3]));

      scan.any_free   = |free_bits;
      scan.first_free = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            scan.first_free = BIT_W'(b);
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/bba_seq.sv -----
// Request sequencer: clearing pass, count pass, grant pass, free update and result register.
`timescale 1ns / 1ps
`default_nettype none

module bba_seq #(
   parameter int  BLOCKS    = 16384,
   parameter int  MAX_ALLOC = 64,
   localparam int NWORDS    = (BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W,
   localparam int WAW       = $clog2(NWORDS),
   localparam int CW        = $clog2(BLOCKS + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  bba_pkg::cfg_type                cfg,

   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_kind,
   input  wire logic [6:0]                 req_count,
   input  wire logic [13:0]                req_block_id,

   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [13:0]                rsp_granted_id,
   output logic      [31:0]                rsp_granted_addr,
   output logic      [1:0]                 rsp_status,
   output logic                            rsp_last,
   output logic      [14:0]                rsp_free_left,

   output logic                            ram_wr_en,
   output logic      [WAW-1:0]             ram_wr_addr,
   output logic      [bba_pkg::WORD_W-1:0] ram_wr_data,
   output logic                            ram_rd_en,
   output logic      [WAW-1:0]             ram_rd_addr,
   input  wire logic [bba_pkg::WORD_W-1:0] ram_rd_data,

   output logic      [bba_pkg::WORD_W-1:0] scan_word,
   output logic      [WAW-1:0]             scan_idx,
   output logic                            scan_first,
   output logic      [bba_pkg::BIT_W-1:0]  scan_start_bit,
   input  bba_pkg::scan_type               scan
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REPLY,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_CNT_RD,
      ST_CNT_CHK,
      ST_AL_RD,
      ST_AL_LOAD,
      ST_AL_PICK
   } state_type;

   state_type         state_ff;
   logic [WAW-1:0]    w_ff;
   logic [CW-1:0]     free_ff;
   logic [6:0]        count_ff;
   logic [6:0]        found_ff;
   logic [6:0]        remaining_ff;
   logic [13:0]       id_ff;
   logic [1:0]        reply_status_ff;
   logic [WORD_W-1:0] cur_word_ff;

   logic              rsp_valid_ff;
   logic [13:0]       rsp_id_ff;
   logic [31:0]       rsp_addr_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_last_ff;
   logic [14:0]       rsp_free_ff;

   logic [WAW-1:0]    start_word;
   logic              out_free;
   logic [WORD_W-1:0] pick_onehot;
   logic [WORD_W-1:0] free_onehot;
   logic [WAW-1:0]    free_word;
   logic              emit_pick;
   logic [6:0]        found_in;
   logic [31:0]       pick_addr;
   logic              rsp_valid_in;

   assign start_word  = WAW'(cfg.data_start >> BIT_W);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pick_onehot = WORD_W'(1) << scan.first_free;
   assign free_onehot = WORD_W'(1) << id_ff[BIT_W-1:0];
   assign free_word   = WAW'(id_ff >> BIT_W);
   assign emit_pick   = (state_ff == ST_AL_PICK) && scan.any_free && out_free;
   assign found_in    = found_ff + 7'(scan.free_cnt);
   assign pick_addr   = 32'(cfg.data_base)
                      + (32'({w_ff, scan.first_free}) << cfg.block_size_log2);
   // load a new result, or hold the current one while it is stalled
   assign rsp_valid_in = ((state_ff == ST_REPLY) && out_free) || emit_pick
                      || (rsp_valid_ff && rsp_stall);

   assign scan_word      = (state_ff == ST_AL_PICK) ? cur_word_ff : ram_rd_data;
   assign scan_idx       = w_ff;
   assign scan_first     = (w_ff == start_word);
   assign scan_start_bit = cfg.data_start[BIT_W-1:0];

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_id   = rsp_id_ff;
   assign rsp_granted_addr = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_free_left    = rsp_free_ff;

   always_comb begin
      ram_rd_en   = (state_ff == ST_CNT_RD) || (state_ff == ST_AL_RD)
                 || (state_ff == ST_FREE_RD);
      ram_rd_addr = (state_ff == ST_FREE_RD) ? free_word : w_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = w_ff;
      ram_wr_data = cur_word_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
         end
         ST_FREE_WR: begin
            ram_wr_en   = |(ram_rd_data & free_onehot);
            ram_wr_addr = free_word;
            ram_wr_data = ram_rd_data & ~free_onehot;
         end
         ST_AL_PICK: begin
            // write back when the word is exhausted or the last block is taken
            if (!scan.any_free) begin
               ram_wr_en = 1'b1;
            end else if (emit_pick && (remaining_ff == 7'd1)) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = cur_word_ff | pick_onehot;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         w_ff         <= '0;
         free_ff      <= CW'(BLOCKS);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_CLEAR: begin
               if (w_ff == WAW'(NWORDS - 1)) begin
                  w_ff     <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  w_ff <= w_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  count_ff <= req_count;
                  id_ff    <= req_block_id;
                  if (req_kind == KIND_FREE) begin
                     if (32'(req_block_id) >= BLOCKS) begin
                        reply_status_ff <= STATUS_BAD_ID;
                        state_ff        <= ST_REPLY;
                     end else begin
                        state_ff <= ST_FREE_RD;
                     end
                  end else if (req_count == 7'd0) begin
                     reply_status_ff <= STATUS_OK;
                     state_ff        <= ST_REPLY;
                  end else if ((32'(req_count) > MAX_ALLOC)
                            || (32'(req_count) > 32'(free_ff))
                            || (32'(cfg.data_start) >= BLOCKS)) begin
                     reply_status_ff <= STATUS_NO_SPACE;
                     state_ff        <= ST_REPLY;
                  end else begin
                     w_ff     <= start_word;
                     found_ff <= '0;
                     state_ff <= ST_CNT_RD;
                  end
               end
            end
            ST_REPLY: begin
               if (out_free) begin
                  rsp_id_ff     <= '0;
                  rsp_addr_ff   <= '0;
                  rsp_status_ff <= reply_status_ff;
                  rsp_last_ff   <= 1'b1;
                  rsp_free_ff   <= 15'(free_ff);
                  state_ff      <= ST_IDLE;
               end
            end
            ST_FREE_RD: begin
               state_ff <= ST_FREE_WR;
            end
            ST_FREE_WR: begin
               if (|(ram_rd_data & free_onehot)) begin
                  free_ff <= free_ff + 1'b1;
               end
               reply_status_ff <= STATUS_OK;
               state_ff        <= ST_REPLY;
            end
            ST_CNT_RD: begin
               state_ff <= ST_CNT_CHK;
            end
            ST_CNT_CHK: begin
               if (found_in >= count_ff) begin
                  // enough free blocks: commit the counter and start granting
                  free_ff      <= free_ff - CW'(count_ff);
                  remaining_ff <= count_ff;
                  w_ff         <= start_word;
                  state_ff     <= ST_AL_RD;
               end else if (w_ff == WAW'(NWORDS - 1)) begin
                  reply_status_ff <= STATUS_NO_SPACE;
                  state_ff        <= ST_REPLY;
               end else begin
                  found_ff <= found_in;
                  w_ff     <= w_ff + 1'b1;
                  state_ff <= ST_CNT_RD;
               end
            end
            ST_AL_RD: begin
               state_ff <= ST_AL_LOAD;
            end
            ST_AL_LOAD: begin
               cur_word_ff <= ram_rd_data;
               state_ff    <= ST_AL_PICK;
            end
            ST_AL_PICK: begin
               if (!scan.any_free) begin
                  w_ff     <= w_ff + 1'b1;
                  state_ff <= ST_AL_RD;
               end else if (out_free) begin
                  rsp_id_ff     <= 14'({w_ff, scan.first_free});
                  rsp_addr_ff   <= pick_addr;
                  rsp_status_ff <= STATUS_OK;
                  rsp_last_ff   <= (remaining_ff == 7'd1);
                  rsp_free_ff   <= 15'(free_ff);
                  cur_word_ff   <= cur_word_ff | pick_onehot;
                  remaining_ff  <= remaining_ff - 1'b1;
                  if (remaining_ff == 7'd1) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(free_ff) <= BLOCKS)
      else $error("free counter above block count");

   a_grant_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AL_PICK) |-> (remaining_ff != 7'd0))
      else $error("grant pass with nothing left to grant");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   a_mid_result_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("non-final result without ok status");

   a_last_grant_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_pick && (remaining_ff == 7'd1)) |=> (state_ff == ST_IDLE))
      else $error("sequencer kept going after final grant");

endmodule

`default_nettype wire

// ----- src/block_bitmap_allocator_top.sv -----
// Top level of the first-fit block bitmap allocator with its register port.
`timescale 1ns / 1ps
`default_nettype none

// Sequencing: refusals, zero counts and bad indexes go straight to the reply state; frees
//   read and rewrite their bitmap word first; an allocate reads and checks words in a count
//   pass, then reads, loads and picks from words in a grant pass, one block per pick.
// Throughput: one request at a time; a new request is taken once the previous one is done.
// Reset: free counter and config registers return to defaults, then a clearing pass
//   over ceil(BLOCKS/32) words (512 by default) zeroes the bitmap while requests stall.
module block_bitmap_allocator_top #(
   parameter int BLOCKS    = 16384,
   parameter int MAX_ALLOC = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,

   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [6:0]  req_count,
   input  wire logic [13:0] req_block_id,

   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [13:0] rsp_granted_id,
   output logic      [31:0] rsp_granted_addr,
   output logic      [1:0]  rsp_status,
   output logic             rsp_last,
   output logic      [14:0] rsp_free_left
);
   import bba_pkg::*;

   localparam int NWORDS = (BLOCKS + WORD_W - 1) / WORD_W;
   localparam int WAW    = $clog2(NWORDS);

   // Configuration registers
   cfg_type    cfg_ff;
   logic [1:0] reg_sel;
   logic       reg_write;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[3:2];
   assign reg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_start      <= '0;
         cfg_ff.data_base       <= '0;
         cfg_ff.block_size_log2 <= 4'd10;
      end else if (reg_write) begin
         unique case (reg_sel)
            REG_DATA_START:  cfg_ff.data_start      <= pwdata[13:0];
            REG_DATA_BASE:   cfg_ff.data_base       <= pwdata[23:0];
            REG_BLOCK_SHIFT: cfg_ff.block_size_log2 <= pwdata[3:0];
            default: begin
               // writes outside the register list are dropped
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_DATA_START:  prdata = 32'(cfg_ff.data_start);
         REG_DATA_BASE:   prdata = 32'(cfg_ff.data_base);
         REG_BLOCK_SHIFT: prdata = 32'(cfg_ff.block_size_log2);
         default:         prdata = '0;
      endcase
   end

   // Bitmap storage and the shared word unit, driven by the sequencer
   logic              ram_wr_en;
   logic [WAW-1:0]    ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [WAW-1:0]    ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   logic [WORD_W-1:0] scan_word;
   logic [WAW-1:0]    scan_idx;
   logic              scan_first;
   logic [BIT_W-1:0]  scan_start_bit;
   scan_type          scan;

   bba_bitmap_ram #(
      .DEPTH (NWORDS),
      .AW    (WAW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bba_word_scan #(
      .BLOCKS (BLOCKS),
      .WAW    (WAW)
   ) u_scan (
      .word       (scan_word),
      .word_idx   (scan_idx),
      .first_word (scan_first),
      .start_bit  (scan_start_bit),
      .scan       (scan)
   );

   bba_seq #(
      .BLOCKS    (BLOCKS),
      .MAX_ALLOC (MAX_ALLOC)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_count        (req_count),
      .req_block_id     (req_block_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted_id   (rsp_granted_id),
      .rsp_granted_addr (rsp_granted_addr),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .rsp_free_left    (rsp_free_left),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .scan_word        (scan_word),
      .scan_idx         (scan_idx),
      .scan_first       (scan_first),
      .scan_start_bit   (scan_start_bit),
      .scan             (scan)
   );

endmodule

`default_nettype wire
